/* rtl/core/bms_pkg.sv */
package bms_pkg;

    // Geometry of the search
    localparam int BLOCK = 16;
    localparam int RANGE = 8;
    localparam int WIN   = BLOCK + 2 * RANGE;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 10;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int SHIFT_W   = 4;
    localparam int SUM_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int SH_IDX_W = $clog2(2 * RANGE);
    localparam int BLK_AW   = $clog2(BLOCK);
    localparam int WIN_AW   = $clog2(WIN);
    localparam int SQ_W     = 2 * PIX_W;
    localparam int GROUP    = 4;
    localparam int NGROUP   = (BLOCK + GROUP - 1) / GROUP;
    localparam int GRP_W    = SQ_W + $clog2(GROUP);
    localparam int EXT_W    = DIM_W + 1;

    // Cycles from a row issue until the best-match registers hold its candidate
    localparam int PIPE_DEPTH = 6;
    localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_BLK = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_LOAD_WIN = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_SEARCH   = KIND_W'(2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = DIM_W'(480);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                capture;
        logic                start;
        logic                ld_read;
        logic                ld_write;
        logic                ld_win;
        logic                issue;
        logic [SH_IDX_W-1:0] sx;
        logic [SH_IDX_W-1:0] sy;
        logic [BLK_AW-1:0]   row;
        logic                publish;
    } bms_cmd_t;

    // Tag that travels with a block row through the difference pipeline
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [SH_IDX_W-1:0] sx;
        logic [SH_IDX_W-1:0] sy;
    } bms_tag_t;

endpackage

/* rtl/core/bms_ram.sv */
module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bms_ctrl.sv */
module bms_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bms_pkg::KIND_W-1:0]  kind,
    output logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        cand_ok,
    output bms_pkg::bms_cmd_t           cmd
);
    import bms_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LD_RD = 3'd1;
    localparam logic [2:0] ST_LD_WR = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [SH_IDX_W-1:0] SH_LAST  = SH_IDX_W'(2 * RANGE - 1);
    localparam logic [BLK_AW-1:0]   ROW_LAST = BLK_AW'(BLOCK - 1);
    localparam logic [DRAIN_W-1:0]  DRAIN_LAST = DRAIN_W'(PIPE_DEPTH - 1);

    logic [2:0]          state_reg, state_next;
    logic                ld_win_reg, ld_win_next;
    logic [SH_IDX_W-1:0] sx_reg, sx_next;
    logic [SH_IDX_W-1:0] sy_reg, sy_next;
    logic [BLK_AW-1:0]   row_reg, row_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance;

    always_comb
    begin
        state_next  = state_reg;
        ld_win_next = ld_win_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        advance     = 1'b0;
        cmd         = '0;
        cmd.sx      = sx_reg;
        cmd.sy      = sy_reg;
        cmd.row     = row_reg;
        cmd.ld_win  = ld_win_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_LOAD_BLK:
                        begin
                            cmd.capture = 1'b1;
                            ld_win_next = 1'b0;
                            state_next  = ST_LD_RD;
                        end
                        KIND_LOAD_WIN:
                        begin
                            cmd.capture = 1'b1;
                            ld_win_next = 1'b1;
                            state_next  = ST_LD_RD;
                        end
                        KIND_SEARCH:
                        begin
                            cmd.capture = 1'b1;
                            cmd.start   = 1'b1;
                            sx_next     = '0;
                            sy_next     = '0;
                            row_next    = '0;
                            state_next  = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LD_RD:
            begin
                cmd.ld_read = 1'b1;
                state_next  = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd.ld_write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RUN:
            begin
                if (cand_ok)
                begin
                    cmd.issue = 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        row_next = '0;
                        advance  = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (sy_reg == SH_LAST)
                    begin
                        sy_next = '0;
                        if (sx_reg == SH_LAST)
                        begin
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            sx_next = sx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sy_next = sy_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    drain_next = drain_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ld_win_reg    <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            row_reg       <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ld_win_reg    <= ld_win_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            row_reg       <= row_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/bms_datapath.sv */
module bms_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bms_pkg::bms_cmd_t                 cmd,
    output logic                              cand_ok,
    input  logic [bms_pkg::SLOT_W-1:0]        slot,
    input  logic [bms_pkg::PIX_W-1:0]         pixel,
    input  logic [bms_pkg::COORD_W-1:0]       block_x,
    input  logic [bms_pkg::COORD_W-1:0]       block_y,
    input  logic                              cfg_write,
    input  logic [bms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bms_pkg::DIM_W-1:0]         cfg_data,
    output logic signed [bms_pkg::SHIFT_W-1:0] shift_x,
    output logic signed [bms_pkg::SHIFT_W-1:0] shift_y,
    output logic [bms_pkg::COORD_W-1:0]       origin_x,
    output logic [bms_pkg::COORD_W-1:0]       origin_y,
    output logic [bms_pkg::SUM_W-1:0]         best_sum,
    output logic                              found
);
    import bms_pkg::*;

    localparam int PIX_SH = $clog2(PIX_W);

    // Configuration and captured request
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic [COORD_W-1:0] org_x_reg, org_y_reg;

    // Stores
    logic [BLOCK*PIX_W-1:0] blk_rdata, blk_wdata;
    logic [WIN*PIX_W-1:0]   win_rdata, win_wdata;
    logic [BLK_AW-1:0]      blk_raddr, blk_ld_row, blk_ld_col;
    logic [WIN_AW-1:0]      win_raddr, win_ld_row, win_ld_col;
    logic                   blk_in_range, blk_we, win_we;

    // Difference pipeline
    bms_tag_t               tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg;
    logic [WIN_AW-1:0]      col_idx [BLOCK];
    logic signed [PIX_W:0]  diff_next [BLOCK];
    logic signed [PIX_W:0]  diff_reg [BLOCK];
    logic signed [2*PIX_W+1:0] prod [BLOCK];
    logic [SQ_W-1:0]        sq_reg [BLOCK];
    logic [GRP_W-1:0]       group_next [NGROUP];
    logic [GRP_W-1:0]       group_reg [NGROUP];
    logic [SUM_W-1:0]       row_sum, acc_next, acc_reg;
    logic                   done_reg;
    logic [SH_IDX_W-1:0]    done_sx_reg, done_sy_reg;

    // Best match
    logic                   found_reg;
    logic [SUM_W-1:0]       best_reg;
    logic [SH_IDX_W-1:0]    best_sx_reg, best_sy_reg;

    // Candidate bounds
    logic [EXT_W-1:0] bx_e, by_e, sx_e, sy_e, w_e, h_e;
    logic             fits, x_ok, y_ok;

    // Result registers
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_y_reg;
    logic [COORD_W-1:0]        origin_x_reg, origin_y_reg;
    logic [SUM_W-1:0]          best_sum_reg;
    logic                      found_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg  <= slot;
            pixel_reg <= pixel;
            org_x_reg <= block_x;
            org_y_reg <= block_y;
        end
    end

    // Bounds of the current candidate
    always_comb
    begin
        bx_e = EXT_W'(org_x_reg);
        by_e = EXT_W'(org_y_reg);
        sx_e = EXT_W'(cmd.sx);
        sy_e = EXT_W'(cmd.sy);
        w_e  = EXT_W'(width_reg);
        h_e  = EXT_W'(height_reg);
        fits = (bx_e + EXT_W'(BLOCK) <= w_e) && (by_e + EXT_W'(BLOCK) <= h_e);
        x_ok = (bx_e + sx_e >= EXT_W'(RANGE))
            && (bx_e + sx_e + EXT_W'(BLOCK) <= w_e + EXT_W'(RANGE));
        y_ok = (by_e + sy_e >= EXT_W'(RANGE))
            && (by_e + sy_e + EXT_W'(BLOCK) <= h_e + EXT_W'(RANGE));
        cand_ok = fits && x_ok && y_ok;
    end

    // Load: read the row, merge the pixel, write it back
    always_comb
    begin
        blk_ld_row   = BLK_AW'(slot_reg / BLOCK);
        blk_ld_col   = BLK_AW'(slot_reg % BLOCK);
        blk_in_range = (32'(slot_reg) < BLOCK * BLOCK);
        win_ld_row   = WIN_AW'(slot_reg / WIN);
        win_ld_col   = WIN_AW'(slot_reg % WIN);
        for (int i = 0; i < BLOCK; i++)
        begin
            blk_wdata[i*PIX_W +: PIX_W] = (blk_ld_col == BLK_AW'(i)) ? pixel_reg
                                                                     : blk_rdata[i*PIX_W +: PIX_W];
        end
        for (int i = 0; i < WIN; i++)
        begin
            win_wdata[i*PIX_W +: PIX_W] = (win_ld_col == WIN_AW'(i)) ? pixel_reg
                                                                     : win_rdata[i*PIX_W +: PIX_W];
        end
        blk_we    = cmd.ld_write && !cmd.ld_win && blk_in_range;
        win_we    = cmd.ld_write && cmd.ld_win && (32'(slot_reg) < WIN * WIN);
        blk_raddr = cmd.ld_read ? blk_ld_row : cmd.row;
        win_raddr = cmd.ld_read ? win_ld_row : WIN_AW'(cmd.row) + WIN_AW'(cmd.sy);
    end

    bms_ram #(
        .WIDTH (BLOCK * PIX_W),
        .DEPTH (BLOCK)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_ld_row),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    bms_ram #(
        .WIDTH (WIN * PIX_W),
        .DEPTH (WIN)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_ld_row),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // Differences, squares and group sums
    always_comb
    begin
        for (int i = 0; i < BLOCK; i++)
        begin
            col_idx[i]   = WIN_AW'(tag_b_reg.sx) + WIN_AW'(i);
            diff_next[i] = $signed({1'b0, blk_rdata[i*PIX_W +: PIX_W]})
                         - $signed({1'b0, win_rdata[{col_idx[i], PIX_SH'(0)} +: PIX_W]});
            prod[i]      = diff_reg[i] * diff_reg[i];
        end
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < BLOCK)
                begin
                    group_next[g] = group_next[g] + GRP_W'(sq_reg[g*GROUP + j]);
                end
            end
        end
        row_sum = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            row_sum = row_sum + SUM_W'(group_reg[g]);
        end
        acc_next = (tag_e_reg.first ? '0 : acc_reg) + row_sum;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK; i++)
        begin
            diff_reg[i] <= diff_next[i];
            sq_reg[i]   <= prod[i][SQ_W-1:0];
        end
        for (int g = 0; g < NGROUP; g++)
        begin
            group_reg[g] <= group_next[g];
        end
        if (tag_e_reg.valid)
        begin
            acc_reg     <= acc_next;
            done_sx_reg <= tag_e_reg.sx;
            done_sy_reg <= tag_e_reg.sy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_b_reg.valid <= cmd.issue;
            tag_b_reg.first <= (cmd.row == '0);
            tag_b_reg.last  <= (cmd.row == BLK_AW'(BLOCK - 1));
            tag_b_reg.sx    <= cmd.sx;
            tag_b_reg.sy    <= cmd.sy;
            tag_c_reg       <= tag_b_reg;
            tag_d_reg       <= tag_c_reg;
            tag_e_reg       <= tag_d_reg;
            done_reg        <= tag_e_reg.valid && tag_e_reg.last;
        end
    end

    // Keep the smallest sum; the later candidate wins a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            best_reg    <= '0;
            best_sx_reg <= '0;
            best_sy_reg <= '0;
        end
        else if (cmd.start)
        begin
            found_reg   <= 1'b0;
            best_reg    <= '0;
            best_sx_reg <= '0;
            best_sy_reg <= '0;
        end
        else if (done_reg && (!found_reg || acc_reg <= best_reg))
        begin
            found_reg   <= 1'b1;
            best_reg    <= acc_reg;
            best_sx_reg <= done_sx_reg;
            best_sy_reg <= done_sy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            shift_x_reg   <= found_reg ? SHIFT_W'(best_sx_reg) - SHIFT_W'(RANGE) : '0;
            shift_y_reg   <= found_reg ? SHIFT_W'(best_sy_reg) - SHIFT_W'(RANGE) : '0;
            origin_x_reg  <= org_x_reg;
            origin_y_reg  <= org_y_reg;
            best_sum_reg  <= best_reg;
            found_out_reg <= found_reg;
        end
    end

    assign shift_x  = shift_x_reg;
    assign shift_y  = shift_y_reg;
    assign origin_x = origin_x_reg;
    assign origin_y = origin_y_reg;
    assign best_sum = best_sum_reg;
    assign found    = found_out_reg;

endmodule

/* rtl/core/block_matching_motion_search.sv */
// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------------
// in        in_valid / in_stall    kind, slot, pixel, block_x, block_y
// out       out_valid / out_stall  shift_x, shift_y, origin_x, origin_y, best_sum, found
// cfg       cfg_write              cfg_index, cfg_data (image_width, image_height)
//
// A load request reads the store row, merges the pixel and writes the row back.
// A search feeds one block row a cycle through the window store read port for
// each shift inside the image, skips each shift outside it, then drains the
// pipeline and publishes its result. Reset restores the image size registers and
// clears the control state; the stores hold nothing until loaded. A stalled result
// sits in the output register while new requests are taken; a finished search
// waits only if the previous result is still held.
module block_matching_motion_search (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bms_pkg::KIND_W-1:0]        kind,
    input  logic [bms_pkg::SLOT_W-1:0]        slot,
    input  logic [bms_pkg::PIX_W-1:0]         pixel,
    input  logic [bms_pkg::COORD_W-1:0]       block_x,
    input  logic [bms_pkg::COORD_W-1:0]       block_y,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bms_pkg::SHIFT_W-1:0] shift_x,
    output logic signed [bms_pkg::SHIFT_W-1:0] shift_y,
    output logic [bms_pkg::COORD_W-1:0]       origin_x,
    output logic [bms_pkg::COORD_W-1:0]       origin_y,
    output logic [bms_pkg::SUM_W-1:0]         best_sum,
    output logic                              found,
    // configuration port
    input  logic                              cfg_write,
    input  logic [bms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bms_pkg::DIM_W-1:0]         cfg_data
);
    import bms_pkg::*;

    bms_cmd_t cmd;
    logic     cand_ok;

    // Controller: walks the shifts, x outer and y inner, and the rows of each
    bms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cand_ok   (cand_ok),
        .cmd       (cmd)
    );

    // Datapath: stores, row difference pipeline, best-match and result registers
    bms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cand_ok   (cand_ok),
        .slot      (slot),
        .pixel     (pixel),
        .block_x   (block_x),
        .block_y   (block_y),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .shift_x   (shift_x),
        .shift_y   (shift_y),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .best_sum  (best_sum),
        .found     (found)
    );

endmodule
